[sv/lcg_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the life cell grid engine.
// No dependencies; every other file imports this package.
package lcg_pkg;

  localparam int DEF_GRID_ROWS = 32;
  localparam int DEF_GRID_COLS = 32;

  localparam int IDX_W    = 5;
  localparam int ACTIVE_W = 6;
  localparam int CMD_W    = 2;
  localparam int CMP_W    = 9;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 6'd32;

  localparam logic REG_ACTIVE_ROWS = 1'b0;
  localparam logic REG_ACTIVE_COLS = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [ACTIVE_W-1:0] active_rows;
    logic [ACTIVE_W-1:0] active_cols;
  } lcg_cfg_t;

  typedef struct packed {
    logic advance;
    logic write_en;
    logic write_alive;
  } lcg_cell_ctrl_t;

endpackage

[sv/lcg_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command input and the result output.
// Depends on lcg_pkg for field widths.
interface lcg_in_if;
  import lcg_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;
  logic             write_alive;

  modport source (output valid, command, row_index, col_index, write_alive, input ready);
  modport sink   (input valid, command, row_index, col_index, write_alive, output ready);
endinterface

interface lcg_out_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic generation_done;

  modport source (output valid, cell_alive, generation_done, input ready);
  modport sink   (input valid, cell_alive, generation_done, output ready);
endinterface

[sv/lcg_cell.sv]
`timescale 1ns / 1ps
// One grid cell: holds its live bit, counts live neighbors, applies B3/S23.
// Depends on lcg_pkg for the control struct.
module lcg_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lcg_pkg::lcg_cell_ctrl_t ctrl,
  input  logic                    sel,
  input  logic                    active,
  input  logic [7:0]              nbr,
  output logic                    alive
);
  import lcg_pkg::*;

  logic       alive_r;
  logic       alive_nxt;
  logic [3:0] count;
  logic       rule;

  always_comb begin
    count = 4'd0;
    for (int i = 0; i < 8; i++) begin
      count = count + {3'b000, nbr[i]};
    end
  end

  assign rule = alive_r ? (count == 4'd2 || count == 4'd3) : (count == 4'd3);

  always_comb begin
    alive_nxt = alive_r;
    if (ctrl.write_en && sel) begin
      alive_nxt = ctrl.write_alive;
    end else if (ctrl.advance && active) begin
      alive_nxt = rule;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= 1'b0;
    end else begin
      alive_r <= alive_nxt;
    end
  end

  assign alive = alive_r;

endmodule

[sv/lcg_cfg.sv]
`timescale 1ns / 1ps
// APB-style register block for the active row and column counts.
// Depends on lcg_pkg for register codes, widths and reset values.
module lcg_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcg_pkg::CFG_AW-1:0]    paddr,
  input  logic [lcg_pkg::CFG_DW-1:0]    pwdata,
  output logic [lcg_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output lcg_pkg::lcg_cfg_t             cfg
);
  import lcg_pkg::*;

  logic [ACTIVE_W-1:0] active_rows_r, active_rows_nxt;
  logic [ACTIVE_W-1:0] active_cols_r, active_cols_nxt;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    active_rows_nxt = active_rows_r;
    active_cols_nxt = active_cols_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_ACTIVE_ROWS: active_rows_nxt = pwdata[ACTIVE_W-1:0];
        REG_ACTIVE_COLS: active_cols_nxt = pwdata[ACTIVE_W-1:0];
        default:         active_rows_nxt = active_rows_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACTIVE_ROWS: prdata = CFG_DW'(active_rows_r);
      REG_ACTIVE_COLS: prdata = CFG_DW'(active_cols_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_rows_r <= ACTIVE_RESET;
      active_cols_r <= ACTIVE_RESET;
    end else begin
      active_rows_r <= active_rows_nxt;
      active_cols_r <= active_cols_nxt;
    end
  end

  assign cfg.active_rows = active_rows_r;
  assign cfg.active_cols = active_cols_r;

endmodule

[sv/life_cell_grid_engine.sv]
`timescale 1ns / 1ps
// Life cell grid engine: a GRID_ROWS x GRID_COLS array of lcg_cell, B3/S23.
// Depends on lcg_pkg, lcg_if, lcg_cell and lcg_cfg.
// Write and advance take effect at the input transfer edge; every active cell updates at once.
// Read path: the row is picked into the pick stage, then the column is picked into the output register.
// Throughput: one item per cycle while the output drains, set by the two-stage read path.
// Synchronous active-low reset clears all cells to dead and sets both active counts to 32.
module life_cell_grid_engine #(
  parameter int GRID_ROWS = lcg_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = lcg_pkg::DEF_GRID_COLS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lcg_in_if.sink                     in_ch,
  lcg_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcg_pkg::CFG_AW-1:0] paddr,
  input  logic [lcg_pkg::CFG_DW-1:0] pwdata,
  output logic [lcg_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import lcg_pkg::*;

  lcg_cfg_t       cfg;
  lcg_cell_ctrl_t ctrl;

  logic [GRID_ROWS-1:0][GRID_COLS-1:0]     alive_w;
  logic [GRID_ROWS-1:0][GRID_COLS-1:0]     masked;
  logic [GRID_ROWS+1:0][GRID_COLS+1:0]     padded;
  logic [GRID_ROWS-1:0]                    row_act, row_hit;
  logic [GRID_COLS-1:0]                    col_act, col_hit;
  logic                                    accept, in_area;
  logic                                    is_write, is_read, is_adv;

  logic                 p1_r, p1_nxt;
  logic                 p1_read_r, p1_adv_r;
  logic [GRID_COLS-1:0] p1_row_r, row_pick;
  logic [IDX_W-1:0]     p1_col_r;
  logic                 p1_move;
  logic                 ov_r, ov_nxt;
  logic                 out_cell_r, out_gen_r, cell_pick;

  lcg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign is_write = in_ch.command == CMD_WRITE;
  assign is_read  = in_ch.command == CMD_READ;
  assign is_adv   = in_ch.command == CMD_ADVANCE;

  assign ctrl.advance     = accept && is_adv;
  assign ctrl.write_en    = accept && is_write;
  assign ctrl.write_alive = in_ch.write_alive;

  always_comb begin
    for (int r = 0; r < GRID_ROWS; r++) begin
      row_act[r] = CMP_W'(r) < CMP_W'(cfg.active_rows);
      row_hit[r] = CMP_W'(in_ch.row_index) == CMP_W'(r);
    end
    for (int c = 0; c < GRID_COLS; c++) begin
      col_act[c] = CMP_W'(c) < CMP_W'(cfg.active_cols);
      col_hit[c] = CMP_W'(in_ch.col_index) == CMP_W'(c);
    end
  end

  assign in_area = (|(row_hit & row_act)) && (|(col_hit & col_act));

  always_comb begin
    padded = '0;
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        masked[r][c]         = alive_w[r][c] & row_act[r] & col_act[c];
        padded[r+1][c+1]     = masked[r][c];
      end
    end
  end

  for (genvar r = 0; r < GRID_ROWS; r++) begin : g_row
    for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
      logic [7:0] nbr;
      assign nbr = {padded[r][c],   padded[r][c+1],   padded[r][c+2],
                    padded[r+1][c],                    padded[r+1][c+2],
                    padded[r+2][c], padded[r+2][c+1], padded[r+2][c+2]};
      lcg_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sel    (row_hit[r] & col_hit[c] & row_act[r] & col_act[c]),
        .active (row_act[r] & col_act[c]),
        .nbr    (nbr),
        .alive  (alive_w[r][c])
      );
    end
  end

  always_comb begin
    row_pick = '0;
    for (int r = 0; r < GRID_ROWS; r++) begin
      if (row_hit[r]) begin
        row_pick = masked[r];
      end
    end
    cell_pick = 1'b0;
    for (int c = 0; c < GRID_COLS; c++) begin
      if (CMP_W'(p1_col_r) == CMP_W'(c)) begin
        cell_pick = p1_row_r[c];
      end
    end
  end

  assign p1_move     = p1_r && (!ov_r || out_ch.ready);
  assign in_ch.ready = !p1_r || p1_move;

  always_comb begin
    p1_nxt = p1_r;
    if (p1_move) begin
      p1_nxt = 1'b0;
    end
    if (accept) begin
      p1_nxt = 1'b1;
    end
    ov_nxt = ov_r;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    if (p1_move) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      p1_r <= p1_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_read_r <= is_read;
      p1_adv_r  <= is_adv;
      p1_row_r  <= row_pick;
      p1_col_r  <= in_ch.col_index;
    end
    if (p1_move) begin
      out_cell_r <= p1_read_r && cell_pick;
      out_gen_r  <= p1_adv_r;
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.cell_alive      = out_cell_r;
  assign out_ch.generation_done = out_gen_r;

  a_adv_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_adv |=> p1_r && p1_adv_r && !p1_read_r)
    else $error("advance transfer did not reach the pick stage");

  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    p1_move |=> ov_r)
    else $error("pick stage drained without filling the output");

  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !(out_cell_r && out_gen_r))
    else $error("read and advance results both set");

  a_outside_write: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_write && !in_area |=> $stable(alive_w))
    else $error("write outside the active area changed the grid");

endmodule
